// ===== design/wssc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wssc_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int HALF_PI_Q16 = 102944;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;
  localparam int SHIFT_W = 6;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] wheel_x;
    logic signed [31:0] wheel_y;
    logic signed [31:0] target_rate;
  } in_word_t;

  typedef struct packed {
    logic signed [17:0] steer_angle;
    logic               reverse_dir;
    logic signed [31:0] wheel_speed;
    logic               speed_saturated;
    logic               degenerate;
  } out_word_t;

  // sideband that travels with each word down the pipe
  typedef struct packed {
    logic signed [31:0]   rate;
    logic [SHIFT_W-1:0]   norm_shift;
    logic                 reverse;
    logic                 degen;
    logic                 vx_zero;
    logic                 vy_pos;
  } side_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [31:0] z;
  } vec_t;

endpackage
`default_nettype wire

// ===== design/wssc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wssc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire wssc_pkg::in_word_t in_word,
  output logic                   out_vld,
  output wssc_pkg::vec_t         out_vec,
  output wssc_pkg::side_t        out_side
);

  // stage A: differences, quarter turn and fold to the right half plane
  logic                  a_vld_r;
  logic signed [33:0]    a_x_r, a_y_r;
  wssc_pkg::side_t       a_side_r;
  logic signed [33:0]    dx, dy, vx, vy;
  wssc_pkg::side_t       a_side_nxt;
  logic signed [33:0]    a_x_nxt, a_y_nxt;

  always_comb begin
    dx = 34'(in_word.wheel_x) - 34'(in_word.center_x);
    dy = 34'(in_word.wheel_y) - 34'(in_word.center_y);
    vx = -dy;
    vy = dx;
    a_side_nxt            = '0;
    a_side_nxt.rate       = in_word.target_rate;
    a_side_nxt.reverse    = vx < 0;
    a_side_nxt.degen      = (vx == 0) && (vy == 0);
    a_side_nxt.vx_zero    = vx == 0;
    a_side_nxt.vy_pos     = vy > 0;
    a_x_nxt = (vx < 0) ? -vx : vx;
    a_y_nxt = (vx < 0) ? -vy : vy;
  end

  // stage B: leading-one position of max magnitude
  logic                  b_vld_r;
  logic signed [33:0]    b_x_r, b_y_r;
  wssc_pkg::side_t       b_side_r;
  wssc_pkg::side_t       b_side_nxt;
  logic [33:0]           mag;
  logic [wssc_pkg::SHIFT_W-1:0] s_nxt;

  always_comb begin
    mag = a_x_r | (a_y_r[33] ? 34'(-a_y_r) : a_y_r);
    s_nxt = '0;
    for (int i = 0; i < 34; i++) begin
      if (mag[i]) begin
        s_nxt = wssc_pkg::SHIFT_W'(60 - i);
      end
    end
    b_side_nxt            = a_side_r;
    b_side_nxt.norm_shift = s_nxt;
  end

  // stage C: normalizing shift
  logic                  c_vld_r;
  wssc_pkg::vec_t        c_vec_r;
  wssc_pkg::side_t       c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_x_r    <= a_x_nxt;
    a_y_r    <= a_y_nxt;
    a_side_r <= a_side_nxt;
    b_x_r    <= a_x_r;
    b_y_r    <= a_y_r;
    b_side_r <= b_side_nxt;
    c_vec_r.x <= 64'(b_x_r) <<< b_side_r.norm_shift;
    c_vec_r.y <= 64'(b_y_r) <<< b_side_r.norm_shift;
    c_vec_r.z <= '0;
    c_side_r  <= b_side_r;
  end

  assign out_vld  = c_vld_r;
  assign out_vec  = c_vec_r;
  assign out_side = c_side_r;

endmodule
`default_nettype wire

// ===== design/wssc_cordic_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wssc_cordic_stage #(
  parameter int ITER = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire wssc_pkg::vec_t   in_vec,
  input  wire wssc_pkg::side_t  in_side,
  output logic                  out_vld,
  output wssc_pkg::vec_t        out_vec,
  output wssc_pkg::side_t       out_side
);

  logic              vld_r;
  wssc_pkg::vec_t    vec_r, vec_nxt;
  wssc_pkg::side_t   side_r;
  logic signed [63:0] xs, ys;

  always_comb begin
    xs = in_vec.x >>> ITER;
    ys = in_vec.y >>> ITER;
    // rotate toward the x axis
    if (!in_vec.y[63]) begin
      vec_nxt.x = in_vec.x + ys;
      vec_nxt.y = in_vec.y - xs;
      vec_nxt.z = in_vec.z + $signed(wssc_pkg::ATAN_Q30[ITER]);
    end else begin
      vec_nxt.x = in_vec.x - ys;
      vec_nxt.y = in_vec.y + xs;
      vec_nxt.z = in_vec.z - $signed(wssc_pkg::ATAN_Q30[ITER]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    vec_r  <= vec_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_vec  = vec_r;
  assign out_side = side_r;

endmodule
`default_nettype wire

// ===== design/wssc_post.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wssc_post (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire wssc_pkg::vec_t   in_vec,
  input  wire wssc_pkg::side_t  in_side,
  output logic                  out_vld,
  output wssc_pkg::out_word_t   out_word
);

  localparam logic signed [17:0] HALF_PI = 18'(wssc_pkg::HALF_PI_Q16);

  // stage A: gain correction, angle rounding and clamp
  logic               a_vld_r;
  logic [31:0]        a_r_r;
  logic signed [17:0] a_angle_r, a_angle_nxt;
  wssc_pkg::side_t    a_side_r;
  logic [61:0]        gain_prod;
  logic signed [31:0] z_rnd;

  always_comb begin
    gain_prod = 62'(in_vec.x[62:31]) * 62'(wssc_pkg::INV_GAIN_Q30);
    z_rnd = in_vec.z + 32'sd8192;
    a_angle_nxt = 18'(z_rnd >>> 14);
    if (in_side.vx_zero) begin
      a_angle_nxt = in_side.vy_pos ? HALF_PI : -HALF_PI;
    end else if (a_angle_nxt > HALF_PI) begin
      a_angle_nxt = HALF_PI;
    end else if (a_angle_nxt < -HALF_PI) begin
      a_angle_nxt = -HALF_PI;
    end
  end

  // stage B: radius times rate magnitude
  logic               b_vld_r;
  logic [63:0]        b_prod_r;
  logic signed [17:0] b_angle_r;
  wssc_pkg::side_t    b_side_r;
  logic [31:0]        rate_abs;

  assign rate_abs = a_side_r.rate[31] ? 32'(-a_side_r.rate) : 32'(a_side_r.rate);

  // stage C: denormalize with rounding, saturate, sign
  logic                  c_vld_r;
  wssc_pkg::out_word_t   c_word_r, c_word_nxt;
  logic [wssc_pkg::SHIFT_W-1:0] sh;
  logic [64:0]           mag;
  logic [64:0]           limit;

  // shift is at least 28 for 33-bit differences, so the scale is a right shift
  always_comb begin
    sh = b_side_r.norm_shift - wssc_pkg::SHIFT_W'(16);
    mag = (65'(b_prod_r >> sh) + 65'd1) >> 1;
    limit = b_side_r.rate[31] ? 65'h080000000 : 65'h07FFFFFFF;
    c_word_nxt = '0;
    c_word_nxt.steer_angle = b_angle_r;
    c_word_nxt.reverse_dir = b_side_r.reverse;
    if (mag > limit) begin
      mag = limit;
      c_word_nxt.speed_saturated = 1'b1;
    end
    c_word_nxt.wheel_speed = b_side_r.rate[31] ? -32'(mag) : 32'(mag);
    if (b_side_r.degen) begin
      c_word_nxt = '0;
      c_word_nxt.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r_r     <= gain_prod[61:30];
    a_angle_r <= a_angle_nxt;
    a_side_r  <= in_side;
    b_prod_r  <= 64'(a_r_r) * 64'(rate_abs);
    b_angle_r <= a_angle_r;
    b_side_r  <= a_side_r;
    c_word_r  <= c_word_nxt;
  end

  assign out_vld  = c_vld_r;
  assign out_word = c_word_r;

endmodule
`default_nettype wire

// ===== design/wheel_steer_angle_and_speed_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake          Payload     Direction
// input     start / busy       in_data     in
// result    out_valid strobe   out_data    out
//
// One word per cycle enters; busy stays low because nothing stalls.
// The pipe has three front stages (difference, leading-one search, normalizing
// shift), one stage per CORDIC iteration and three back stages (gain multiply,
// rate multiply, rounding and saturation).
// Reset is synchronous, active low, and clears only the valid chain.
// out_valid is a one-cycle strobe; the receiver takes every result.
module wheel_steer_angle_and_speed_core #(
  parameter int CORDIC_ITERATIONS = wssc_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire wssc_pkg::in_word_t   in_data,
  output logic                      out_valid,
  output wssc_pkg::out_word_t       out_data
);

  localparam int LATENCY = CORDIC_ITERATIONS + 6;

  logic accept;
  // the pipe never stalls, so a new word is welcome every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  logic            vld   [CORDIC_ITERATIONS+1];
  wssc_pkg::vec_t  vec   [CORDIC_ITERATIONS+1];
  wssc_pkg::side_t side  [CORDIC_ITERATIONS+1];

  // difference, quarter turn, fold to right half plane, normalize
  wssc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .in_word  (in_data),
    .out_vld  (vld[0]),
    .out_vec  (vec[0]),
    .out_side (side[0])
  );

  // one CORDIC vectoring iteration per stage
  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cordic
    wssc_cordic_stage #(
      .ITER (g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (vld[g]),
      .in_vec   (vec[g]),
      .in_side  (side[g]),
      .out_vld  (vld[g+1]),
      .out_vec  (vec[g+1]),
      .out_side (side[g+1])
    );
  end

  // magnitude scaling, speed saturation, angle clamp
  wssc_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld[CORDIC_ITERATIONS]),
    .in_vec   (vec[CORDIC_ITERATIONS]),
    .in_side  (side[CORDIC_ITERATIONS]),
    .out_vld  (out_valid),
    .out_word (out_data)
  );

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("result strobe missing after fixed latency");

  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |-> (out_data.steer_angle == 0 &&
      out_data.wheel_speed == 0 && !out_data.reverse_dir && !out_data.speed_saturated))
    else $error("degenerate word carries nonzero fields");

  a_angle_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.steer_angle <= 18'sd102944 &&
      out_data.steer_angle >= -18'sd102944))
    else $error("steering angle out of range");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int ITERS = wssc_pkg::CORDIC_ITERATIONS_DEF;
  localparam int LATENCY = ITERS + 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 800;

  // Truncated atan(2^-i) in Q2.30, one entry per CORDIC step.
  localparam longint ARCTAN_STEP [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  wssc_pkg::in_word_t  in_data;
  logic                out_valid;
  wssc_pkg::out_word_t out_data;

  wssc_pkg::in_word_t  pending_words[$];
  wssc_pkg::out_word_t expected_steer[$];
  int        pause_marks[$];
  int        errors;
  int        cycles;
  int        sent;
  int        checked;
  int        gap_left;
  bit        stim_done;
  int        n_degen;
  int        n_sat;
  int        n_reverse;

  wheel_steer_angle_and_speed_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Floor division by 2^s, exact for negative values.
  function automatic longint floor_div2(longint v, int s);
    return v >>> s;
  endfunction

  // Work out steering angle and wheel speed for one word.
  function automatic wssc_pkg::out_word_t steer_kinematics(wssc_pkg::in_word_t w);
    wssc_pkg::out_word_t res;
    longint dx, dy, rate, vx, vy, x, y, z, xs, ys, ang, speed;
    longint unsigned m, r, mag, lim, prod, arate;
    int s, sh;
    dx = longint'(w.wheel_x) - longint'(w.center_x);
    dy = longint'(w.wheel_y) - longint'(w.center_y);
    rate = longint'(w.target_rate);
    vx = -dy;
    vy = dx;
    res = '0;
    if (vx == 0 && vy == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    x = vx;
    y = vy;
    z = 0;
    if (vx < 0) begin
      res.reverse_dir = 1'b1;
      x = -x;
      y = -y;
    end
    m = longint'(x) | longint'(y < 0 ? -y : y);
    s = 0;
    while (m < (64'd1 << 60)) begin
      m = m << 1;
      s++;
    end
    x = x <<< s;
    y = y <<< s;
    for (int i = 0; i < ITERS && i < 32; i++) begin
      xs = floor_div2(x, i);
      ys = floor_div2(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_STEP[i];
      end
    end
    if (vx == 0) begin
      ang = (vy > 0) ? wssc_pkg::HALF_PI_Q16 : -wssc_pkg::HALF_PI_Q16;
    end else begin
      ang = floor_div2(z + 8192, 14);
      if (ang > wssc_pkg::HALF_PI_Q16) ang = wssc_pkg::HALF_PI_Q16;
      if (ang < -wssc_pkg::HALF_PI_Q16) ang = -wssc_pkg::HALF_PI_Q16;
    end
    r = ((longint'(x) >> 31) * 64'd652032875) >> 30;
    arate = (rate < 0) ? -rate : rate;
    prod = r * arate;
    lim = (rate < 0) ? 64'h80000000 : 64'h7FFFFFFF;
    if (s <= 15) begin
      sh = 15 - s;
      if (prod > (lim >> sh)) begin
        mag = lim;
        res.speed_saturated = 1'b1;
      end else begin
        mag = prod << sh;
      end
    end else begin
      sh = s - 15;
      mag = (sh >= 64) ? 0 : ((prod >> (sh - 1)) + 1) >> 1;
      if (mag > lim) begin
        mag = lim;
        res.speed_saturated = 1'b1;
      end
    end
    speed = (rate < 0) ? -longint'(mag) : longint'(mag);
    res.steer_angle = ang[17:0];
    res.wheel_speed = speed[31:0];
    return res;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 2000)) - 1000);
      2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)};
      default: return 32'(int'($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic wssc_pkg::in_word_t rand_word();
    wssc_pkg::in_word_t w;
    w.center_x = rand_coord();
    w.center_y = rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        w.wheel_x = w.center_x;
        w.wheel_y = w.center_y;
      end
      1: begin
        w.wheel_x = w.center_x;
        w.wheel_y = rand_coord();
      end
      2: begin
        w.wheel_x = rand_coord();
        w.wheel_y = w.center_y;
      end
      3: begin
        w.wheel_x = w.center_x + 32'(int'($urandom_range(0, 8)) - 4);
        w.wheel_y = w.center_y + 32'(int'($urandom_range(0, 8)) - 4);
      end
      default: begin
        w.wheel_x = rand_coord();
        w.wheel_y = rand_coord();
      end
    endcase
    case ($urandom_range(0, 3))
      0: w.target_rate = $urandom;
      1: w.target_rate = 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      default: w.target_rate = 32'(int'($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
    return w;
  endfunction

  function automatic wssc_pkg::in_word_t mk(int cx, int cy, int wx, int wy, int rt);
    wssc_pkg::in_word_t w;
    w.center_x = cx;
    w.center_y = cy;
    w.wheel_x = wx;
    w.wheel_y = wy;
    w.target_rate = rt;
    return w;
  endfunction

  // Append one word to the stimulus queue.
  function automatic void queue_word(wssc_pkg::in_word_t w);
    pending_words = {pending_words, w};
  endfunction

  initial begin
    localparam int MAXI = 32'h7FFFFFFF;
    localparam int MINI = 32'h80000000;
    // wheel on center, pure forward / backward / side offsets, extremes
    queue_word(mk(0, 0, 0, 0, 1 << 16));
    queue_word(mk(MAXI, MINI, MAXI, MINI, MAXI));
    queue_word(mk(0, 0, 1 << 16, 0, 1 << 16));
    queue_word(mk(0, 0, -(1 << 16), 0, 1 << 16));
    queue_word(mk(0, 0, 0, 1 << 16, 1 << 16));
    queue_word(mk(0, 0, 0, -(1 << 16), -(1 << 16)));
    queue_word(mk(0, 0, 1 << 16, 1 << 16, 1 << 16));
    queue_word(mk(0, 0, 1 << 16, -(1 << 16), 1 << 16));
    queue_word(mk(MINI, MINI, MAXI, MAXI, MAXI));
    queue_word(mk(MAXI, MAXI, MINI, MINI, MINI));
    queue_word(mk(MINI, MAXI, MAXI, MINI, MINI));
    queue_word(mk(MAXI, MINI, MINI, MAXI, MAXI));
    queue_word(mk(0, 0, 1, 0, 1));
    queue_word(mk(0, 0, 0, -1, -1));
    queue_word(mk(0, 0, 1, 1, 0));
    queue_word(mk(0, 0, 5 << 16, 0, MINI));
    queue_word(mk(-1, -1, 0, 0, -1));
    queue_word(mk(0, 0, 3 << 16, -(4 << 16), 2 << 16));
    queue_word(mk(0, 0, 1000 << 16, 0, 1000 << 16));
    queue_word(mk(0, 0, 0, 1, MAXI));
    pause_marks = {pause_marks, pending_words.size()};
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) pause_marks = {pause_marks, pending_words.size()};
      queue_word(rand_word());
    end
    stim_done = 1'b1;
  end

  // Driver: present a word on start, hold while busy, insert gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      gap_left <= 0;
    end else if (start && busy) begin
      // hold the word until it is taken
    end else begin
      if (start) sent <= sent + 1;
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pause_marks.size() > 0 &&
                   pause_marks[0] == sent + (start ? 1 : 0) &&
                   (expected_steer.size() > 0 || start)) begin
        // drain every result before moving on
        start <= 1'b0;
      end else if (pending_words.size() > 0) begin
        if (pause_marks.size() > 0 && pause_marks[0] == sent + (start ? 1 : 0))
          void'(pause_marks.pop_front());
        start <= 1'b1;
        in_data <= pending_words.pop_front();
        case ($urandom_range(0, 19))
          0: gap_left <= $urandom_range(20, 60);
          1, 2, 3, 4, 5: gap_left <= $urandom_range(1, 3);
          default: gap_left <= 0;
        endcase
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Predict at acceptance so the expectation is queued before the result.
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      expected_steer = {expected_steer, steer_kinematics(in_data)};
  end

  // Monitor: compare every strobed result with the oldest expectation.
  always @(posedge clk) begin
    wssc_pkg::out_word_t exp_w;
    if (rst_n && out_valid) begin
      if (expected_steer.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        errors++;
      end else begin
        exp_w = expected_steer.pop_front();
        checked++;
        if (exp_w.degenerate) n_degen++;
        if (exp_w.speed_saturated) n_sat++;
        if (exp_w.reverse_dir) n_reverse++;
        if (out_data.steer_angle !== exp_w.steer_angle) begin
          $error("steer_angle exp %0d got %0d", exp_w.steer_angle, out_data.steer_angle);
          errors++;
        end
        if (out_data.reverse_dir !== exp_w.reverse_dir) begin
          $error("reverse_dir exp %0b got %0b", exp_w.reverse_dir, out_data.reverse_dir);
          errors++;
        end
        if (out_data.wheel_speed !== exp_w.wheel_speed) begin
          $error("wheel_speed exp %0d got %0d", exp_w.wheel_speed, out_data.wheel_speed);
          errors++;
        end
        if (out_data.speed_saturated !== exp_w.speed_saturated) begin
          $error("speed_saturated exp %0b got %0b", exp_w.speed_saturated,
                 out_data.speed_saturated);
          errors++;
        end
        if (out_data.degenerate !== exp_w.degenerate) begin
          $error("degenerate exp %0b got %0b", exp_w.degenerate, out_data.degenerate);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    sent = 0;
    checked = 0;
    n_degen = 0;
    n_sat = 0;
    n_reverse = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (pending_words.size() > 0 || start || expected_steer.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("checked %0d results: %0d on-center, %0d clipped speeds, %0d reversed",
             checked, n_degen, n_sat, n_reverse);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== wheel_steer_angle_and_speed_core.f =====
design/wssc_pkg.sv
design/wssc_front.sv
design/wssc_cordic_stage.sv
design/wssc_post.sv
design/wheel_steer_angle_and_speed_core.sv
sim/tb_top.sv
